// ===== rtl/pbt_pkg.sv =====
`timescale 1ns / 1ps

package pbt_pkg;

	localparam int SLOT_W  = 6;
	localparam int COLOR_W = 24;
	localparam int TIME_W  = 16;

	// item kinds
	localparam logic [1:0] KIND_ADD  = 2'd0;
	localparam logic [1:0] KIND_DEL  = 2'd1;
	localparam logic [1:0] KIND_UPD  = 2'd2;
	localparam logic [1:0] KIND_TICK = 2'd3;

	// status codes
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_FULL     = 2'd1;
	localparam logic [1:0] STAT_INACTIVE = 2'd2;

	typedef struct packed {
		logic [1:0]        kind;
		logic [SLOT_W-1:0] slot_id;
		logic [7:0]        palette_index;
		logic [7:0]        on_red;
		logic [7:0]        on_green;
		logic [7:0]        on_blue;
		logic [7:0]        off_red;
		logic [7:0]        off_green;
		logic [7:0]        off_blue;
		logic [TIME_W-1:0] on_frames;
		logic [TIME_W-1:0] off_frames;
	} item_t;

	typedef struct packed {
		logic              is_palette_write;
		logic [7:0]        write_index;
		logic [7:0]        write_red;
		logic [7:0]        write_green;
		logic [7:0]        write_blue;
		logic [1:0]        status;
		logic [SLOT_W-1:0] result_slot;
		logic              last;
	} result_t;

	// one light as held in the store; liveness is kept outside in flops
	typedef struct packed {
		logic               on;
		logic [TIME_W-1:0]  count;
		logic [7:0]         pal_index;
		logic [COLOR_W-1:0] lit_rgb;
		logic [COLOR_W-1:0] dark_rgb;
		logic [TIME_W-1:0]  lit_len;
		logic [TIME_W-1:0]  dark_len;
	} entry_t;

	typedef struct packed {
		logic    valid;
		result_t data;
	} emit_t;

	function automatic result_t palette_write(entry_t e, logic [SLOT_W-1:0] slot);
		result_t r;
		r = '0;
		r.is_palette_write = 1'b1;
		r.write_index = e.pal_index;
		{r.write_red, r.write_green, r.write_blue} = e.on ? e.lit_rgb : e.dark_rgb;
		r.result_slot = slot;
		return r;
	endfunction

	function automatic result_t status_result(logic [1:0] code, logic [SLOT_W-1:0] slot);
		result_t r;
		r = '0;
		r.status = code;
		r.result_slot = slot;
		r.last = 1'b1;
		return r;
	endfunction

endpackage

// ===== rtl/pbt_store.sv =====
`timescale 1ns / 1ps

module pbt_store import pbt_pkg::*; #(
	parameter int NUM_LIGHTS = 32,
	parameter int IDX_W = 5
) (
	input  logic             clk,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_addr,
	output entry_t           rd_data,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_addr,
	input  entry_t           wr_data
);

	entry_t mem [NUM_LIGHTS];

	// single write port, single registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/pbt_seq.sv =====
`timescale 1ns / 1ps

module pbt_seq import pbt_pkg::*; #(
	parameter int NUM_LIGHTS = 32,
	parameter int IDX_W = 5
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  item_t            item,
	input  logic             out_free,
	output emit_t            emit,
	output logic             rd_en,
	output logic [IDX_W-1:0] rd_addr,
	input  entry_t           rd_data,
	output logic             wr_en,
	output logic [IDX_W-1:0] wr_addr,
	output entry_t           wr_data
);

	localparam int CNT_W = $clog2(NUM_LIGHTS + 1);

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_CHECK    = 3'd1;
	localparam logic [2:0] S_UPD_EX   = 3'd2;
	localparam logic [2:0] S_ADD      = 3'd3;
	localparam logic [2:0] S_ADD_EMIT = 3'd4;
	localparam logic [2:0] S_TICK     = 3'd5;
	localparam logic [2:0] S_STATUS   = 3'd6;

	logic [2:0]            state_q;
	item_t                 item_q;
	logic [NUM_LIGHTS-1:0] live_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  s1_valid_q;
	logic [IDX_W-1:0]      s1_idx_q;
	logic [1:0]            stat_code_q;
	logic [SLOT_W-1:0]     stat_slot_q;

	logic [IDX_W-1:0]  cnt_idx;
	logic [IDX_W-1:0]  sid_idx;
	logic              slot_ok;
	logic              issue;
	logic              cnt_dead;
	logic              s1_live;
	logic [TIME_W-1:0] limit;
	logic [TIME_W:0]   cnt_inc;
	logic              flip;
	logic              stall;
	entry_t            tick_ent;
	entry_t            upd_ent;
	entry_t            add_ent;

	assign cnt_idx  = cnt_q[IDX_W-1:0];
	assign sid_idx  = item_q.slot_id[IDX_W-1:0];
	assign slot_ok  = (item_q.slot_id < SLOT_W'(NUM_LIGHTS)) && live_q[sid_idx];
	assign issue    = (cnt_q != CNT_W'(NUM_LIGHTS));
	assign cnt_dead = issue && !live_q[cnt_idx];
	assign s1_live  = live_q[s1_idx_q];

	// tick: counter advance and on/off flip
	assign limit   = rd_data.on ? rd_data.lit_len : rd_data.dark_len;
	assign cnt_inc = {1'b0, rd_data.count} + {{TIME_W{1'b0}}, 1'b1};
	assign flip    = (cnt_inc >= {1'b0, limit});
	assign stall   = s1_valid_q && s1_live && flip && !out_free;

	always_comb begin
		tick_ent = rd_data;
		tick_ent.count = flip ? '0 : cnt_inc[TIME_W-1:0];
		tick_ent.on = rd_data.on ^ flip;

		upd_ent = rd_data;
		upd_ent.lit_rgb  = {item_q.on_red, item_q.on_green, item_q.on_blue};
		upd_ent.dark_rgb = {item_q.off_red, item_q.off_green, item_q.off_blue};
		upd_ent.lit_len  = item_q.on_frames;
		upd_ent.dark_len = item_q.off_frames;

		add_ent.on        = 1'b0;
		add_ent.count     = '0;
		add_ent.pal_index = item_q.palette_index;
		add_ent.lit_rgb   = upd_ent.lit_rgb;
		add_ent.dark_rgb  = upd_ent.dark_rgb;
		add_ent.lit_len   = item_q.on_frames;
		add_ent.dark_len  = item_q.off_frames;
	end

	assign item_ready = (state_q == S_IDLE);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = cnt_idx;
		wr_en   = 1'b0;
		wr_addr = cnt_idx;
		wr_data = tick_ent;
		emit    = '0;
		unique case (state_q)
			S_CHECK: begin
				if (item_q.kind == KIND_UPD && slot_ok) begin
					rd_en   = 1'b1;
					rd_addr = sid_idx;
				end
			end
			S_UPD_EX: begin
				if (out_free) begin
					wr_en      = 1'b1;
					wr_addr    = sid_idx;
					wr_data    = upd_ent;
					emit.valid = 1'b1;
					emit.data  = palette_write(upd_ent, item_q.slot_id);
				end
			end
			S_ADD: begin
				if (cnt_dead) begin
					wr_en   = 1'b1;
					wr_data = add_ent;
				end
			end
			S_ADD_EMIT: begin
				emit.valid = out_free;
				emit.data  = palette_write(add_ent, stat_slot_q);
			end
			S_TICK: begin
				rd_en = issue && !stall;
				if (s1_valid_q && s1_live && !stall) begin
					wr_en      = 1'b1;
					wr_addr    = s1_idx_q;
					emit.valid = flip;
					emit.data  = palette_write(tick_ent, SLOT_W'(s1_idx_q));
				end
			end
			S_STATUS: begin
				emit.valid = out_free;
				emit.data  = status_result(stat_code_q, stat_slot_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			live_q      <= '0;
			cnt_q       <= '0;
			s1_valid_q  <= 1'b0;
			s1_idx_q    <= '0;
			stat_code_q <= STAT_OK;
			stat_slot_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						cnt_q      <= '0;
						s1_valid_q <= 1'b0;
						if (item.kind == KIND_ADD) begin
							state_q <= S_ADD;
						end else if (item.kind == KIND_TICK) begin
							state_q <= S_TICK;
						end else begin
							state_q <= S_CHECK;
						end
					end
				end
				S_CHECK: begin
					stat_slot_q <= item_q.slot_id;
					if (!slot_ok) begin
						stat_code_q <= STAT_INACTIVE;
						state_q     <= S_STATUS;
					end else if (item_q.kind == KIND_DEL) begin
						live_q[sid_idx] <= 1'b0;
						stat_code_q     <= STAT_OK;
						state_q         <= S_STATUS;
					end else begin
						stat_code_q <= STAT_OK;
						state_q     <= S_UPD_EX;
					end
				end
				S_UPD_EX: begin
					if (out_free) begin
						state_q <= S_STATUS;
					end
				end
				S_ADD: begin
					if (!issue) begin
						stat_code_q <= STAT_FULL;
						stat_slot_q <= '0;
						state_q     <= S_STATUS;
					end else if (cnt_dead) begin
						live_q[cnt_idx] <= 1'b1;
						stat_code_q     <= STAT_OK;
						stat_slot_q     <= SLOT_W'(cnt_q);
						state_q         <= S_ADD_EMIT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_ADD_EMIT: begin
					if (out_free) begin
						state_q <= S_STATUS;
					end
				end
				S_TICK: begin
					if (!stall) begin
						s1_valid_q <= issue;
						s1_idx_q   <= cnt_idx;
						if (issue) begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
					if (!issue && !s1_valid_q) begin
						stat_code_q <= STAT_OK;
						stat_slot_q <= '0;
						state_q     <= S_STATUS;
					end
				end
				S_STATUS: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// item payload, no reset needed
	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_q <= item;
		end
	end

endmodule

// ===== rtl/palette_blink_table.sv =====
`timescale 1ns / 1ps

// palette_blink_table: table of blinking palette lights
//
// item channel (item_valid / item_ready / item): one transaction is one command,
// add, delete, update or frame tick. the block takes a new command only when
// the previous one has issued all of its results.
// result channel (result_valid / result_ready / result): palette writes in slot
// order, then one closing status transaction flagged by last.
// add scans the live flags up to the first dead slot; tick walks the whole light
// store, one read per cycle over its single read port while the walk is not
// stalled, read-modify-write pipelined one slot behind the read.
// results leave through a registered output; a stalled receiver holds the result
// register and the walk pauses on the slot whose palette write is waiting,
// nothing is dropped.
// reset clears all live flags, so every slot reads as dead; the store itself
// is not cleared, as a dead slot's contents are never looked at.
module palette_blink_table import pbt_pkg::*; #(
	parameter int NUM_LIGHTS = 32
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_ready,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	// store address width, at least one bit
	localparam int IDX_W = (NUM_LIGHTS > 1) ? $clog2(NUM_LIGHTS) : 1;

	logic             out_free;
	emit_t            emit;
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	entry_t           rd_data;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	entry_t           wr_data;

	logic    result_valid_q;
	result_t result_q;

	// sequencer: command decode, live flags, tick walk
	pbt_seq #(
		.NUM_LIGHTS (NUM_LIGHTS),
		.IDX_W      (IDX_W)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.out_free   (out_free),
		.emit       (emit),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data)
	);

	// per-light colours, times and counters
	pbt_store #(
		.NUM_LIGHTS (NUM_LIGHTS),
		.IDX_W      (IDX_W)
	) u_store (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	// output register: free when empty or being taken this cycle
	assign out_free = !result_valid_q || result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (emit.valid) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.valid) begin
			result_q <= emit.data;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
